// ===== sv/u2dec_pkg.sv =====
package u2dec_pkg;

    // Sequencer states of the converter
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } u2dec_state_t;

    localparam int unsigned NUM_W   = 64;
    localparam int unsigned CHAR_W  = 6;
    localparam int unsigned DIGIT_W = 4;

    // Decimal base and the ASCII code of '0', cut to the character width
    localparam logic [DIGIT_W-1:0] DIGIT_BASE = 4'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;

    // Double dabble correction: a digit of five or more gets three added
    // before the shift, so that it carries cleanly into the next digit.
    function automatic logic [DIGIT_W-1:0] dabble_adjust(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        r = d;
        if (d >= (DIGIT_BASE >> 1))
        begin
            r = d + 4'd3;
        end
        return r;
    endfunction

endpackage

// ===== sv/u2dec_ifs.sv =====
interface u2dec_num_if
    import u2dec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [NUM_W-1:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface u2dec_char_if
    import u2dec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/unsigned_to_decimal_ascii.sv =====
// Channel   Modport  Payload                        Meaning
// number    sink     value[63:0]                    unsigned number to convert
// digits    source   character[5:0], last           ASCII digit, MSD first; last on LSD
//
// One number: a load, shift-and-add-3 over all VALUE_BITS bits in the shared BCD unit, then
// dropping of leading zeros and emitting of one digit per cycle while digits is ready.
// number.ready is high only while idle. A stall on digits holds the digit and freezes the
// emit sequence.
// The final digit may wait in the output register while the next number is taken.
// Reset (rst_n low) empties the sequencer and the output.
module unsigned_to_decimal_ascii
    import u2dec_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    u2dec_num_if.sink          number,
    u2dec_char_if.source       digits
);

    // Digits needed for a VALUE_BITS number: floor(bits * log10(2)) + 1
    localparam int unsigned BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    // BCD register spans at least the output window
    localparam int unsigned ND     = (BCD_DIGITS > MAX_DIGITS) ? BCD_DIGITS : MAX_DIGITS;
    localparam int unsigned BCD_W  = ND * DIGIT_W;
    localparam int unsigned IDX_W  = $clog2(ND);
    localparam int unsigned PTR_W  = $clog2(MAX_DIGITS);
    localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);

    typedef logic [ND-1:0][DIGIT_W-1:0] bcd_t;

    u2dec_state_t state_reg, state_next;

    // Shared conversion unit: binary shift register feeding the BCD register
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    bcd_t                  bcd_reg, bcd_next;
    bcd_t                  bcd_adj;
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [PTR_W-1:0]      ptr_reg, ptr_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic                  last_reg, last_next;

    logic                  in_take;
    logic                  out_load;
    logic                  window_ovf;
    logic [DIGIT_W-1:0]    cur_digit;

    assign number.ready     = (state_reg == ST_IDLE);
    assign in_take          = number.valid && number.ready;
    assign digits.valid     = out_valid_reg;
    assign digits.character = char_reg;
    assign digits.last      = last_reg;

    // Output register may take a new digit when empty or being drained
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || digits.ready);
    assign cur_digit = bcd_reg[IDX_W'(ptr_reg)];

    // Add-3 correction on every digit in parallel
    always_comb
    begin
        for (int i = 0; i < ND; i++)
        begin
            bcd_adj[i] = dabble_adjust(bcd_reg[i]);
        end
    end

    // Any nonzero digit above the window means the number was cut: keep the
    // window's leading zeros in that case.
    always_comb
    begin
        window_ovf = 1'b0;
        for (int i = 0; i < ND; i++)
        begin
            if (i >= MAX_DIGITS)
            begin
                window_ovf = window_ovf | (bcd_reg[i] != '0);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == CNT_W'(1))
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (window_ovf || (ptr_reg == '0) || (cur_digit != '0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && (ptr_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and output register
    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (digits.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    bin_next     = number.value[VALUE_BITS-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = CNT_W'(VALUE_BITS);
                    ptr_next     = PTR_W'(MAX_DIGITS - 1);
                end
            end
            ST_CONV:
            begin
                // Shift one bit of the binary word into the corrected BCD word
                bcd_next     = bcd_t'(BCD_W'({bcd_adj, bin_reg[VALUE_BITS-1]}));
                bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
            ST_SKIP:
            begin
                // Drop one leading zero per cycle
                if (!window_ovf && (ptr_reg != '0) && (cur_digit == '0))
                begin
                    ptr_next = ptr_reg - PTR_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = ASCII_ZERO + CHAR_W'(cur_digit);
                    last_next      = (ptr_reg == '0);
                    if (ptr_reg != '0)
                    begin
                        ptr_next = ptr_reg - PTR_W'(1);
                    end
                end
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            ptr_reg       <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // A taken number starts a full-length conversion
    a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_CONV) && (bit_cnt_reg == CNT_W'(VALUE_BITS)))
        else $error("conversion did not start after a taken number");

    // Conversion ends after the last bit and moves on to zero skipping
    a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) && (bit_cnt_reg == CNT_W'(1)) |=> (state_reg == ST_SKIP))
        else $error("conversion did not end on its last bit");

    // Only decimal digits leave the block
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digits.valid |-> (digits.character >= ASCII_ZERO) &&
                         (digits.character <= ASCII_ZERO + CHAR_W'(9)))
        else $error("non-digit character on output");

    // Loading the least significant digit flags last and frees the input
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (ptr_reg == '0) |=> digits.valid && digits.last && number.ready)
        else $error("final digit not flagged or input not released");

endmodule
